/* src/multi_channel_stepper_tone_generator_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the stepper tone generator
// Shared helpers for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_STEPPER_TONE_GENERATOR_DEFINES_SVH
`define MULTI_CHANNEL_STEPPER_TONE_GENERATOR_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define MCSTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcstg check failed in the following cycle");

// The consequent must hold in the same cycle as the antecedent.
`define MCSTG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcstg check failed in the same cycle");

`endif

/* src/mcstg_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper tone generator package
// Widths, codes, reset values and the structs shared by the modules.
// ---------------------------------------------------------------------------
package mcstg_pkg;

   // Default channel count; the response words carry pins for 1 to 6 channels.
   localparam int CHANNELS_DEFAULT = 6;

   // Field widths of the request and response words.
   localparam int DELTA_W  = 32;
   localparam int CHAN_W   = 3;
   localparam int PERIOD_W = 20;
   localparam int STORE_W  = PERIOD_W + 1;
   localparam int POS_W    = 8;
   localparam int PIN_COUNT = 6;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_METHOD  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POSITION = 1'b1;

   // Command codes.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   // Step method codes.
   localparam logic METHOD_SLIDE = 1'b0;
   localparam logic METHOD_OSC   = 1'b1;

   localparam logic [POS_W-1:0] MAX_POS_RESET = 8'd72;

   // Per-word control that every channel sees.
   typedef struct packed {
      logic                tick;
      logic                method;
      logic [POS_W-1:0]    max_pos;
      logic [DELTA_W-1:0]  delta;
      logic [PERIOD_W-1:0] period;
   } chan_ctrl_type;

   // Pin levels reported by one channel.
   typedef struct packed {
      logic dir;
      logic step;
      logic led;
   } chan_pins_type;

endpackage

/* src/mcstg_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper tone generator channels
// Valid/ready interfaces for the request and response words.
// ---------------------------------------------------------------------------
interface mcstg_req_if;
   import mcstg_pkg::*;

   logic                valid;
   logic                ready;
   logic                command;
   logic [DELTA_W-1:0]  delta_us;
   logic [CHAN_W-1:0]   channel;
   logic [PERIOD_W-1:0] period;

   modport source (output valid, command, delta_us, channel, period, input ready);
   modport sink (input valid, command, delta_us, channel, period, output ready);
endinterface

interface mcstg_rsp_if;
   import mcstg_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PIN_COUNT-1:0] dir_pins;
   logic [PIN_COUNT-1:0] step_pins;
   logic [PIN_COUNT-1:0] led_pins;

   modport source (output valid, dir_pins, step_pins, led_pins, input ready);
   modport sink (input valid, dir_pins, step_pins, led_pins, output ready);
endinterface

/* src/mcstg_channel.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper tone channel
// Holds one channel's period, elapsed time, arm position and pin levels and
// updates them for each accepted word.
// ---------------------------------------------------------------------------
module mcstg_channel (
   input  logic                   clock,
   input  logic                   reset,
   input  mcstg_pkg::chan_ctrl_type ctrl,
   input  logic                   set_en,
   output mcstg_pkg::chan_pins_type pins
);
   import mcstg_pkg::*;

   logic [STORE_W-1:0] period_ff, period_in;
   logic [DELTA_W-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               dir_ff, dir_in;
   logic               step_ff, step_in;
   logic               led_ff, led_in;

   logic [DELTA_W:0]   sum;
   logic [DELTA_W-1:0] sat;
   logic               due;
   logic               dir_mid;
   logic               step_new;

   // Saturating add of the elapsed time and compare against the period.
   assign sum = {1'b0, elapsed_ff} + {1'b0, ctrl.delta};
   assign sat = sum[DELTA_W] ? {DELTA_W{1'b1}} : sum[DELTA_W-1:0];
   assign due = (sat >= {{(DELTA_W-STORE_W){1'b0}}, period_ff});

   // Sliding mode turns around at the track ends before toggling.
   always_comb begin
      if (pos_ff >= ctrl.max_pos) begin
         dir_mid = 1'b1;
      end else if (pos_ff == '0) begin
         dir_mid = 1'b0;
      end else begin
         dir_mid = dir_ff;
      end
   end

   assign step_new = ~step_ff;

   // Next state for a set or a tick.
   always_comb begin
      period_in  = period_ff;
      elapsed_in = elapsed_ff;
      pos_in     = pos_ff;
      dir_in     = dir_ff;
      step_in    = step_ff;
      led_in     = led_ff;
      if (set_en) begin
         period_in = (ctrl.method == METHOD_OSC) ? {1'b0, ctrl.period}
                                                 : {ctrl.period, 1'b0};
         led_in    = (ctrl.period != '0);
      end else if (ctrl.tick && (period_ff != '0)) begin
         if (due) begin
            elapsed_in = '0;
            step_in    = step_new;
            if (ctrl.method == METHOD_OSC) begin
               dir_in = step_ff ? ~dir_ff : dir_ff;
            end else begin
               dir_in = dir_mid;
               if (step_new) begin
                  if (dir_mid) begin
                     if (pos_ff != '0) begin
                        pos_in = pos_ff - 1'b1;
                     end
                  end else begin
                     if (pos_ff != {POS_W{1'b1}}) begin
                        pos_in = pos_ff + 1'b1;
                     end
                  end
               end
            end
         end else begin
            elapsed_in = sat;
         end
      end
   end

   // Channel state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         elapsed_ff <= '0;
         pos_ff     <= '0;
         dir_ff     <= 1'b0;
         step_ff    <= 1'b0;
         led_ff     <= 1'b0;
      end else begin
         period_ff  <= period_in;
         elapsed_ff <= elapsed_in;
         pos_ff     <= pos_in;
         dir_ff     <= dir_in;
         step_ff    <= step_in;
         led_ff     <= led_in;
      end
   end

   assign pins.dir  = dir_ff;
   assign pins.step = step_ff;
   assign pins.led  = led_ff;

endmodule

/* src/multi_channel_stepper_tone_generator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi-channel stepper tone generator
// Plays a square-wave tone on each stepper channel by toggling its step pin
// whenever the channel's elapsed time reaches its loaded period.
// ---------------------------------------------------------------------------
// Each request word is either a set (load one channel's half period, doubled
// in sliding mode, and light its LED when nonzero) or a tick (add delta_us to
// every sounding channel and step those that are due). Every word produces
// one response word with the direction, step and LED levels of all channels
// after the update. All channels update in parallel from the word, and the
// channel state registers themselves form the response word, so a new word is
// accepted in every cycle the response is taken or empty. The user is to write
// configuration through the csr_ port while the block idles; this is unchecked.
// ---------------------------------------------------------------------------
module multi_channel_stepper_tone_generator #(
   parameter int CHANNELS = mcstg_pkg::CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   mcstg_req_if.sink                        req_chan,
   mcstg_rsp_if.source                      rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [mcstg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcstg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mcstg_pkg::*;

`include "multi_channel_stepper_tone_generator_defines.svh"

   logic             method_ff;
   logic [POS_W-1:0] max_pos_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             set_ch0_on;
   chan_ctrl_type    ctrl;
   chan_pins_type    pins_w [CHANNELS];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff  <= METHOD_SLIDE;
         max_pos_ff <= MAX_POS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_METHOD:  method_ff  <= csr_wdata[0];
            CSR_MAX_POSITION: max_pos_ff <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // A word is taken whenever the response slot is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Control broadcast to all channels.
   assign ctrl.tick    = accept && (req_chan.command == CMD_TICK);
   assign ctrl.method  = method_ff;
   assign ctrl.max_pos = max_pos_ff;
   assign ctrl.delta   = req_chan.delta_us;
   assign ctrl.period  = req_chan.period;

   // One channel instance per stepper; sets to absent channels match none.
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      mcstg_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .set_en (accept && (req_chan.command == CMD_SET)
                  && (req_chan.channel == CHAN_W'(c))),
         .pins   (pins_w[c])
      );
   end

   // Gather the pin levels into the response word.
   for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
      if (p < CHANNELS) begin : g_used
         assign rsp_chan.dir_pins[p]  = pins_w[p].dir;
         assign rsp_chan.step_pins[p] = pins_w[p].step;
         assign rsp_chan.led_pins[p]  = pins_w[p].led;
      end else begin : g_unused
         assign rsp_chan.dir_pins[p]  = 1'b0;
         assign rsp_chan.step_pins[p] = 1'b0;
         assign rsp_chan.led_pins[p]  = 1'b0;
      end
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   // A set word that loads a nonzero period into channel 0.
   assign set_ch0_on = accept && (req_chan.command == CMD_SET)
                       && (req_chan.channel == '0) && (req_chan.period != '0);

   // Checks on the word flow and on the set path.
   `MCSTG_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_chan.valid)
   `MCSTG_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_chan.ready, !accept)
   `MCSTG_ASSERT_NEXT(a_set_lights_led, clock, reset, set_ch0_on, rsp_chan.led_pins[0])

endmodule

/* tb/sv/mcstg_pin_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pin level checker for the stepper tone generator
// Watches the request, response and configuration ports, keeps its own copy
// of every channel's period, elapsed time, arm position and pin levels, and
// compares each response word with the pin levels predicted for it.
// ---------------------------------------------------------------------------
module mcstg_pin_checker #(
   parameter int CHANNELS = mcstg_pkg::CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   mcstg_req_if                             req_mon,
   mcstg_rsp_if                             rsp_mon,
   input  logic                             csr_wr_en,
   input  logic [mcstg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcstg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               mismatch_count,
   output int                               words_pending
);
   import mcstg_pkg::*;

   // Pin levels of all channels as one response word carries them.
   typedef struct packed {
      logic [PIN_COUNT-1:0] dir;
      logic [PIN_COUNT-1:0] step;
      logic [PIN_COUNT-1:0] led;
   } pin_levels_type;

   // Pin levels owed by the block, oldest first.
   pin_levels_type levels_due[$];

   // Channel state, eight slots so that any channel index fits.
   logic [STORE_W-1:0] half_period[8];
   logic [DELTA_W-1:0] elapsed[8];
   logic [POS_W-1:0]   arm_pos[8];
   logic [7:0]         dir_bit;
   logic [7:0]         step_bit;
   logic [7:0]         led_bit;

   // Configuration as last written.
   logic               method;
   logic [POS_W-1:0]   max_pos;

   // All three ports are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin : watch
      pin_levels_type   got;
      pin_levels_type   want;
      logic [DELTA_W:0] sum;
      if (reset) begin
         levels_due.delete();
         method   = METHOD_SLIDE;
         max_pos  = MAX_POS_RESET;
         dir_bit  = '0;
         step_bit = '0;
         led_bit  = '0;
         for (int c = 0; c < 8; c++) begin
            half_period[c] = '0;
            elapsed[c]     = '0;
            arm_pos[c]     = '0;
         end
      end else begin
         // Register writes are to be made only while no word is in flight; the block does not enforce this.
         if (csr_wr_en) begin
            if (csr_index == CSR_STEP_METHOD) begin
               method = csr_wdata[0];
            end else if (csr_index == CSR_MAX_POSITION) begin
               max_pos = csr_wdata[POS_W-1:0];
            end
         end

         // Each response word is matched against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.dir_pins, rsp_mon.step_pins, rsp_mon.led_pins};
            if (levels_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: response word with none outstanding: dir %h step %h led %h",
                           $time, got.dir, got.step, got.led);
               end
            end else begin
               want = levels_due.pop_front();
               if (got.dir !== want.dir || got.step !== want.step
                   || got.led !== want.led) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"%0t: pin mismatch: dir exp %h got %h, ",
                               "step exp %h got %h, led exp %h got %h"},
                              $time, want.dir, got.dir, want.step, got.step,
                              want.led, got.led);
                  end
               end
            end
         end

         // An accepted request word updates the channels and owes one response.
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.command == CMD_SET) begin
               // Channels past the last one are ignored; the elapsed count is kept.
               if (req_mon.channel < CHANNELS) begin
                  half_period[req_mon.channel] = (method == METHOD_OSC) ?
                     {1'b0, req_mon.period} : {req_mon.period, 1'b0};
                  led_bit[req_mon.channel] = (req_mon.period != '0);
               end
            end else begin
               for (int c = 0; c < CHANNELS; c++) begin
                  // Silent channels ignore the tick entirely.
                  if (half_period[c] != '0) begin
                     sum = {1'b0, elapsed[c]} + req_mon.delta_us;
                     elapsed[c] = sum[DELTA_W] ? '1 : sum[DELTA_W-1:0];
                     if (elapsed[c] >= half_period[c]) begin
                        elapsed[c] = '0;
                        if (method == METHOD_OSC) begin
                           // Direction flips on each step taken while the pin is high.
                           if (step_bit[c]) begin
                              dir_bit[c] = ~dir_bit[c];
                           end
                           step_bit[c] = ~step_bit[c];
                        end else begin
                           // Turn around at the track ends, then move on a rising step.
                           if (arm_pos[c] >= max_pos) begin
                              dir_bit[c] = 1'b1;
                           end else if (arm_pos[c] == '0) begin
                              dir_bit[c] = 1'b0;
                           end
                           step_bit[c] = ~step_bit[c];
                           if (step_bit[c]) begin
                              if (dir_bit[c]) begin
                                 if (arm_pos[c] != '0) begin
                                    arm_pos[c] = arm_pos[c] - 1'b1;
                                 end
                              end else if (arm_pos[c] != '1) begin
                                 arm_pos[c] = arm_pos[c] + 1'b1;
                              end
                           end
                        end
                     end
                  end
               end
            end
            levels_due.push_back({dir_bit[PIN_COUNT-1:0], step_bit[PIN_COUNT-1:0],
                                  led_bit[PIN_COUNT-1:0]});
         end
      end
      words_pending <= levels_due.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper tone generator testbench
// Drives set and tick words through the request channel under both step
// methods and track lengths, with random gaps on both sides and one long
// response stall, and gives the verdict from the pin level checker.
// ---------------------------------------------------------------------------
module testbench;
   import mcstg_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int req_idle_pct;
   int rsp_idle_pct;
   int hold_asked;
   int hold_served;
   int hold_left;
   int mismatch_count;
   int words_pending;

   mcstg_req_if req_bus ();
   mcstg_rsp_if rsp_bus ();

   multi_channel_stepper_tone_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mcstg_pin_checker pin_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always #2 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 300;
         hold_served <= hold_asked;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offer one request word, with a random gap first, and wait until it is taken.
   task automatic send_word(input logic cmd, input logic [DELTA_W-1:0] delta,
                            input logic [CHAN_W-1:0] chan,
                            input logic [PERIOD_W-1:0] period);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.delta_us <= delta;
      req_bus.channel  <= chan;
      req_bus.period   <= period;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Mostly short periods and small deltas so that channels step often.
   task automatic send_random_word();
      logic [DELTA_W-1:0]  delta;
      logic [PERIOD_W-1:0] period;
      delta  = $urandom();
      period = PERIOD_W'($urandom());
      if ($urandom_range(99) < 30) begin
         case ($urandom_range(9))
            0:       period = '0;
            1, 2:    ;
            default: period = PERIOD_W'($urandom_range(12, 1));
         endcase
         send_word(CMD_SET, delta, CHAN_W'($urandom_range(7)), period);
      end else begin
         case ($urandom_range(9))
            0:       delta = '0;
            1:       delta = '1;
            2:       ;
            default: delta = $urandom_range(30, 0);
         endcase
         send_word(CMD_TICK, delta, CHAN_W'($urandom_range(7)), period);
      end
   endtask

   // Stop offering words and wait until every response word has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the step method register, then the max position register.
   task automatic set_mode(input logic method, input logic [POS_W-1:0] max_pos);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STEP_METHOD;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, method};
      @(posedge clock);
      csr_index <= CSR_MAX_POSITION;
      csr_wdata <= max_pos;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_TICK;
      req_bus.delta_us = '0;
      req_bus.channel  = '0;
      req_bus.period   = '0;
      rsp_bus.ready    = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_STEP_METHOD;
      csr_wdata        = '0;
      req_idle_pct     = 19;
      rsp_idle_pct     = 49;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_mode(METHOD_SLIDE, MAX_POS_RESET);

      // A tick with every channel silent changes nothing.
      send_word(CMD_TICK, '1, 3'd2, 20'h12345);
      // Load periods at both extremes; delta is ignored by a set.
      send_word(CMD_SET, '1, 3'd0, 20'd1);
      send_word(CMD_SET, 32'h0, 3'd1, '1);
      send_word(CMD_SET, 32'h5A5A5A5A, 3'd5, 20'd3);
      // Channels past the last one are ignored.
      send_word(CMD_SET, 32'h0, 3'd6, 20'd4);
      send_word(CMD_SET, 32'h0, 3'd7, '1);
      // Channel and period fields are ignored by a tick.
      send_word(CMD_TICK, 32'd0, 3'd7, '1);
      send_word(CMD_TICK, 32'd1, 3'd0, 20'd0);
      send_word(CMD_TICK, 32'd2, 3'd3, 20'd9);
      send_word(CMD_TICK, 32'd5, 3'd1, 20'd0);
      // The long channel has counted up, so this tick saturates its count.
      send_word(CMD_TICK, '1, 3'd0, 20'd0);
      // A new period while counting keeps the elapsed count.
      send_word(CMD_SET, 32'd0, 3'd2, 20'd50);
      send_word(CMD_TICK, 32'd20, 3'd0, 20'd0);
      send_word(CMD_SET, 32'd0, 3'd2, 20'd10);
      send_word(CMD_TICK, 32'd0, 3'd0, 20'd0);
      // A zero period silences the channel and turns its LED off.
      send_word(CMD_SET, 32'd0, 3'd3, 20'd0);
      send_word(CMD_SET, 32'd0, 3'd0, 20'd0);
      send_word(CMD_SET, 32'd0, 3'd4, 20'h55555);
      send_word(CMD_TICK, 32'hAAAAAAAA, 3'd5, 20'hAAAAA);
      send_word(CMD_TICK, '1, 3'd0, 20'd0);

      // Long response stall while words keep coming, so the input backs up.
      hold_asked = hold_asked + 1;
      repeat (250) send_random_word();
      drain();

      // Oscillating mode on the longest track.
      set_mode(METHOD_OSC, 8'd255);
      req_idle_pct = 49;
      rsp_idle_pct = 19;
      repeat (250) send_random_word();
      drain();

      // Sliding on the shortest legal track, no idling on either side.
      set_mode(METHOD_SLIDE, 8'd1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (150) send_random_word();
      drain();

      // A zero track length pins the direction toward zero.
      set_mode(METHOD_SLIDE, 8'd0);
      repeat (50) send_random_word();
      drain();

      set_mode(METHOD_SLIDE, 8'd2);
      repeat (100) send_random_word();
      drain();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/mcstg_pkg.sv
src/mcstg_if.sv
src/mcstg_channel.sv
src/multi_channel_stepper_tone_generator.sv
tb/sv/mcstg_pin_checker.sv
tb/sv/testbench.sv
